[rtl/core/gn2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2_pkg: shared types, constants and lookups for the 2D gradient noise core
// Permutation ROM, gradient codes, datapath widths and the queue entry type.
// ----------------------------------------------------------------------------
package gn2_pkg;

  // Internal fixed point: IFB fraction bits, 1.0 = 2^IFB
  localparam int IFB     = 24;
  localparam int T_W     = 24;  // cell fraction, unsigned
  localparam int INNER_W = 28;  // 15 - 6t and 10 - p terms
  localparam int F_W     = 25;  // fade value, 0 .. 1.0 inclusive
  localparam int SUM_W   = 27;  // signed gradient sum (+-dx +-dy)
  localparam int N_W     = 26;  // corner dot product
  localparam int D_W     = 27;  // first lerp difference
  localparam int NX_W    = 27;  // first lerp result
  localparam int R_W     = 28;  // final lerp result

  localparam logic signed [SUM_W-1:0] FX_ONE   = 27'sd16777216;
  localparam logic signed [24:0]      INV_RT2  = 25'sd11863283;
  localparam logic [INNER_W-1:0]      FADE_K15 = 28'd251658240;  // 15.0
  localparam logic [INNER_W-1:0]      FADE_K10 = 28'd167772160;  // 10.0

  // Gradient codes: low 3 bits of a corner hash
  localparam logic [2:0] GRAD_PX = 3'd0;  // (+1, 0)
  localparam logic [2:0] GRAD_NX = 3'd1;  // (-1, 0)
  localparam logic [2:0] GRAD_PY = 3'd2;  // (0, +1)
  localparam logic [2:0] GRAD_NY = 3'd3;  // (0, -1)
  localparam logic [2:0] GRAD_PP = 3'd4;  // (+d, +d)
  localparam logic [2:0] GRAD_NP = 3'd5;  // (-d, +d)
  localparam logic [2:0] GRAD_PN = 3'd6;  // (+d, -d)
  localparam logic [2:0] GRAD_NN = 3'd7;  // (-d, -d)

  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  // Corner order in hash arrays: 0 = (0,0), 1 = (1,0), 2 = (0,1), 3 = (1,1)
  typedef struct packed {
    logic [3:0][2:0] hash;
    logic [T_W-1:0]  tx;
    logic [T_W-1:0]  ty;
  } gn2_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gn2_qstat_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

  // Gradient dot product before the 1/sqrt2 scale: axes give +-dx or +-dy
  // directly, diagonals give the signed sum that is scaled afterwards.
  function automatic logic signed [SUM_W-1:0] grad_sum(
    input logic [2:0]              code,
    input logic signed [SUM_W-1:0] dx,
    input logic signed [SUM_W-1:0] dy
  );
    logic signed [SUM_W-1:0] s;
    unique case (code)
      GRAD_PX: s = dx;
      GRAD_NX: s = -dx;
      GRAD_PY: s = dy;
      GRAD_NY: s = -dy;
      GRAD_PP: s = dx + dy;
      GRAD_NP: s = dy - dx;
      GRAD_PN: s = dx - dy;
      GRAD_NN: s = -dx - dy;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/gn2_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2_front: request intake and corner hashing
// Splits coordinates into cell and fraction, runs the permutation chain over
// three stages and pushes one hashed entry per request into the queue.
// ----------------------------------------------------------------------------
module gn2_front
  import gn2_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        coord_valid,
  output logic        coord_stall,
  input  logic [23:0] x_coord,
  input  logic [23:0] y_coord,
  input  gn2_qstat_t  qstat,
  output logic        push,
  output gn2_entry_t  push_data
);

  localparam logic [23:0] FRAC_MASK = 24'((64'd1 << COORD_FRAC_BITS) - 64'd1);
  localparam int          UP_SHIFT  = IFB - COORD_FRAC_BITS;

  logic           en;
  logic [2:0]     vld;
  logic [7:0]     ix, iy;
  logic [T_W-1:0] tx, ty;

  logic [7:0]     f1_a, f1_b;
  logic [T_W-1:0] f1_tx, f1_ty;
  logic [7:0]     f2_ha0, f2_ha1, f2_hb0, f2_hb1;
  logic [T_W-1:0] f2_tx, f2_ty;
  gn2_entry_t     f3_entry;

  // Whole front holds only when a finished entry cannot enter the queue
  assign en          = !(vld[2] && qstat.full);
  assign coord_stall = !en;
  assign push        = vld[2] && !qstat.full;
  assign push_data   = f3_entry;

  assign ix = 8'(x_coord >> COORD_FRAC_BITS);
  assign iy = 8'(y_coord >> COORD_FRAC_BITS);
  assign tx = T_W'((x_coord & FRAC_MASK) << UP_SHIFT);
  assign ty = T_W'((y_coord & FRAC_MASK) << UP_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], coord_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_a   <= perm(ix) + iy;
      f1_b   <= perm(ix + 8'd1) + iy;
      f1_tx  <= tx;
      f1_ty  <= ty;

      f2_ha0 <= perm(f1_a);
      f2_ha1 <= perm(f1_a + 8'd1);
      f2_hb0 <= perm(f1_b);
      f2_hb1 <= perm(f1_b + 8'd1);
      f2_tx  <= f1_tx;
      f2_ty  <= f1_ty;

      f3_entry.hash[0] <= 3'(perm(f2_ha0));
      f3_entry.hash[1] <= 3'(perm(f2_hb0));
      f3_entry.hash[2] <= 3'(perm(f2_ha1));
      f3_entry.hash[3] <= 3'(perm(f2_hb1));
      f3_entry.tx      <= f2_tx;
      f3_entry.ty      <= f2_ty;
    end
  end

endmodule

[rtl/core/gn2_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2_queue: short FIFO between the hashing front and the arithmetic back
// Register array with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module gn2_queue
  import gn2_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  gn2_entry_t push_data,
  input  logic       pop,
  output gn2_entry_t pop_data,
  output gn2_qstat_t qstat
);

  gn2_entry_t      mem [QDEPTH];
  logic [QA_W-1:0] wr_ptr, rd_ptr;
  logic [QC_W-1:0] count;

  assign pop_data    = mem[rd_ptr];
  assign qstat.full  = (count == QC_W'(QDEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QDEPTH)) else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

[rtl/core/gn2_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2_back: fade, gradient dot products, bilinear blend and output scaling
// Nine arithmetic stages plus the output register, frozen as one on stall.
// ----------------------------------------------------------------------------
module gn2_back
  import gn2_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  gn2_qstat_t         qstat,
  input  gn2_entry_t         pop_data,
  output logic               pop,
  output logic               noise_valid,
  input  logic               noise_stall,
  output logic signed [15:0] noise_value
);

  localparam int RW1 = R_W + 1;
  localparam int SC_W = 36;

  logic       en;
  logic [8:0] vld;

  // s1: offsets, gradient sums, fade inner terms
  logic signed [SUM_W-1:0] dx0, dx1, dy0, dy1;
  logic signed [SUM_W-1:0] s1_sum [4];
  logic [3:0]              s1_diag;
  logic [T_W-1:0]          s1_tx, s1_ty;
  logic [INNER_W-1:0]      s1_inx, s1_iny;

  // s2: t^2, p, corner dots
  logic signed [50:0]      cp [4];
  logic [47:0]             ttx, tty;
  logic [51:0]             tix, tiy;
  logic [T_W-1:0]          s2_t2x, s2_t2y, s2_tx, s2_ty;
  logic [INNER_W-1:0]      s2_px, s2_py;
  logic signed [N_W-1:0]   s2_n [4];

  // s3: t^3, q
  logic [47:0]             t3x_full, t3y_full;
  logic [T_W-1:0]          s3_t3x, s3_t3y;
  logic [INNER_W-1:0]      s3_qx, s3_qy;
  logic signed [N_W-1:0]   s3_n [4];

  // s4: fade values, first differences
  logic [51:0]             fux, fvy;
  logic [F_W-1:0]          s4_u, s4_v;
  logic signed [D_W-1:0]   s4_d0, s4_d1;
  logic signed [N_W-1:0]   s4_n00, s4_n01;

  // s5: first lerp products
  logic signed [52:0]      pm0, pm1;
  logic signed [28:0]      s5_m0, s5_m1;
  logic signed [N_W-1:0]   s5_n00, s5_n01;
  logic [F_W-1:0]          s5_v;

  // s6..s9: first lerp sums, second lerp
  logic signed [NX_W-1:0]  s6_nx0, s6_nx1;
  logic [F_W-1:0]          s6_v;
  logic signed [R_W-1:0]   s7_d;
  logic signed [NX_W-1:0]  s7_nx0;
  logic [F_W-1:0]          s7_v;
  logic signed [53:0]      pm;
  logic signed [29:0]      s8_ms;
  logic signed [NX_W-1:0]  s8_nx0;
  logic signed [R_W-1:0]   s9_r;

  logic signed [SC_W-1:0]  scaled;
  logic signed [15:0]      noise_value_next;

  assign en  = !(noise_valid && noise_stall);
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      noise_valid <= 1'b0;
    end else if (en) begin
      vld         <= {vld[7:0], !qstat.empty};
      noise_valid <= vld[8];
    end
  end

  always_comb begin
    dx0 = $signed({3'b000, pop_data.tx});
    dy0 = $signed({3'b000, pop_data.ty});
    dx1 = dx0 - FX_ONE;
    dy1 = dy0 - FX_ONE;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cp[k] = 51'(s1_sum[k]) * 51'(INV_RT2);
    end
    ttx      = 48'(s1_tx) * 48'(s1_tx);
    tty      = 48'(s1_ty) * 48'(s1_ty);
    tix      = 52'(s1_tx) * 52'(s1_inx);
    tiy      = 52'(s1_ty) * 52'(s1_iny);
    t3x_full = 48'(s2_t2x) * 48'(s2_tx);
    t3y_full = 48'(s2_t2y) * 48'(s2_ty);
    fux      = 52'(s3_t3x) * 52'(s3_qx);
    fvy      = 52'(s3_t3y) * 52'(s3_qy);
    pm0      = 53'($signed({1'b0, s4_u})) * 53'(s4_d0);
    pm1      = 53'($signed({1'b0, s4_u})) * 53'(s4_d1);
    pm       = 54'($signed({1'b0, s7_v})) * 54'(s7_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // s1
      s1_sum[0] <= grad_sum(pop_data.hash[0], dx0, dy0);
      s1_sum[1] <= grad_sum(pop_data.hash[1], dx1, dy0);
      s1_sum[2] <= grad_sum(pop_data.hash[2], dx0, dy1);
      s1_sum[3] <= grad_sum(pop_data.hash[3], dx1, dy1);
      for (int k = 0; k < 4; k++) begin
        s1_diag[k] <= pop_data.hash[k][2];
      end
      s1_tx  <= pop_data.tx;
      s1_ty  <= pop_data.ty;
      s1_inx <= FADE_K15 - INNER_W'({pop_data.tx, 2'b00}) - INNER_W'({pop_data.tx, 1'b0});
      s1_iny <= FADE_K15 - INNER_W'({pop_data.ty, 2'b00}) - INNER_W'({pop_data.ty, 1'b0});

      // s2
      for (int k = 0; k < 4; k++) begin
        s2_n[k] <= s1_diag[k] ? N_W'(cp[k] >>> IFB) : N_W'(s1_sum[k]);
      end
      s2_t2x <= ttx[47:24];
      s2_t2y <= tty[47:24];
      s2_px  <= tix[51:24];
      s2_py  <= tiy[51:24];
      s2_tx  <= s1_tx;
      s2_ty  <= s1_ty;

      // s3
      s3_t3x <= t3x_full[47:24];
      s3_t3y <= t3y_full[47:24];
      s3_qx  <= FADE_K10 - s2_px;
      s3_qy  <= FADE_K10 - s2_py;
      s3_n   <= s2_n;

      // s4
      s4_u   <= fux[48:24];
      s4_v   <= fvy[48:24];
      s4_d0  <= D_W'(s3_n[1]) - D_W'(s3_n[0]);
      s4_d1  <= D_W'(s3_n[3]) - D_W'(s3_n[2]);
      s4_n00 <= s3_n[0];
      s4_n01 <= s3_n[2];

      // s5
      s5_m0  <= 29'(pm0 >>> IFB);
      s5_m1  <= 29'(pm1 >>> IFB);
      s5_n00 <= s4_n00;
      s5_n01 <= s4_n01;
      s5_v   <= s4_v;

      // s6
      s6_nx0 <= NX_W'(29'(s5_n00) + s5_m0);
      s6_nx1 <= NX_W'(29'(s5_n01) + s5_m1);
      s6_v   <= s5_v;

      // s7
      s7_d   <= R_W'(s6_nx1) - R_W'(s6_nx0);
      s7_nx0 <= s6_nx0;
      s7_v   <= s6_v;

      // s8
      s8_ms  <= 30'(pm >>> IFB);
      s8_nx0 <= s7_nx0;

      // s9
      s9_r   <= R_W'(30'(s8_nx0) + s8_ms);

      noise_value <= noise_value_next;
    end
  end

  // Rescale to OUT_FRAC_BITS: round half up when bits drop, else shift up
  if (OUT_FRAC_BITS < IFB) begin : g_round
    localparam int OSH = IFB - OUT_FRAC_BITS;
    localparam logic signed [RW1-1:0] HALF = RW1'(64'sd1 <<< (OSH - 1));
    logic signed [RW1-1:0] rnd;
    assign rnd    = RW1'(s9_r) + HALF;
    assign scaled = SC_W'(rnd >>> OSH);
  end else begin : g_widen
    assign scaled = SC_W'(s9_r) <<< (OUT_FRAC_BITS - IFB);
  end

  always_comb begin
    priority if (scaled > 36'sd32767) begin
      noise_value_next = 16'sh7fff;
    end else if (scaled < -36'sd32768) begin
      noise_value_next = 16'sh8000;
    end else begin
      noise_value_next = 16'(scaled);
    end
  end

endmodule

[rtl/core/gradient_noise_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d: 2D Perlin noise, one sample a cycle unless stalled
// Front hashes lattice corners, a short queue decouples it from the back
// end, which evaluates fade curves, gradient dots and the bilinear blend.
// ----------------------------------------------------------------------------
// Takes one coordinate request per clock while coord_stall is low and
// returns one Q1.14 noise sample per request, in order. The datapath is fully
// pipelined, so the sustained rate is one request per cycle while neither
// side stalls; a sample passes 3 hashing stages, 1 queue entry, 9 arithmetic
// stages and the output register, the first of which loads at the edge that
// accepts its request. The front chains three reads of the constant
// permutation ROM; the back carries two fade polynomials, four gradient dot
// products and three lerps through one multiplier rank per stage. A stall on
// the noise side freezes the back end as a whole; the front keeps accepting
// until the 4-entry queue is full and the last of its own three stages holds
// an entry, then raises coord_stall. Coordinates are unsigned fixed point with
// COORD_FRAC_BITS fraction bits; the cell index wraps modulo 256. There is no
// configuration and no state beyond the pipeline, so reset only empties it.
// ----------------------------------------------------------------------------
module gradient_noise_2d
  import gn2_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 14
) (
  input  logic               clk,
  input  logic               rst,
  // coordinate requests
  input  logic               coord_valid,
  output logic               coord_stall,
  input  logic [23:0]        x_coord,
  input  logic [23:0]        y_coord,
  // noise samples
  output logic               noise_valid,
  input  logic               noise_stall,
  output logic signed [15:0] noise_value
);

  gn2_qstat_t qstat;
  gn2_entry_t push_data;
  gn2_entry_t pop_data;
  logic       push;
  logic       pop;

  // Corner hashing: cell split, permutation chain, gradient code per corner
  gn2_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .qstat       (qstat),
    .push        (push),
    .push_data   (push_data)
  );

  // Slack between the hashing front and the stallable arithmetic back
  gn2_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // Fade, dot products, blend, rounding and saturation to 16 bits
  gn2_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .pop_data    (pop_data),
    .pop         (pop),
    .noise_valid (noise_valid),
    .noise_stall (noise_stall),
    .noise_value (noise_value)
  );

endmodule

[verif/gn2_noise_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2_noise_checker: scoreboard for the 2D gradient noise core
// Recomputes every accepted coordinate request and checks the noise samples
// in order against the recomputed values.
// ----------------------------------------------------------------------------
module gn2_noise_checker
  import gn2_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               coord_valid,
  input  logic               coord_stall,
  input  logic [23:0]        x_coord,
  input  logic [23:0]        y_coord,
  input  logic               noise_valid,
  input  logic               noise_stall,
  input  logic signed [15:0] noise_value,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int     FB       = 24;
  localparam longint UNIT     = 64'sd16777216;
  localparam longint DIAG     = 64'sd11863283;
  localparam int     SCALE_UP = (OUT_FRAC_BITS >= FB) ? OUT_FRAC_BITS - FB : 0;
  localparam int     SCALE_DN = (OUT_FRAC_BITS < FB) ? FB - OUT_FRAC_BITS : 1;

  localparam logic [7:0] PERM_TABLE [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  typedef struct {
    logic [23:0]        x;
    logic [23:0]        y;
    logic signed [15:0] value;
  } noise_expect_t;

  noise_expect_t pending_samples [$];

  function automatic logic [7:0] perm_at(input int unsigned i);
    return PERM_TABLE[i & 255];
  endfunction

  // quintic 6t^5 - 15t^4 + 10t^3, all terms truncated at 24 fraction bits
  function automatic longint fade_curve(input longint t);
    longint t2, t3, p;
    t2 = (t * t) >>> FB;
    t3 = (t2 * t) >>> FB;
    p  = (t * (15 * UNIT - 6 * t)) >>> FB;
    return (t3 * (10 * UNIT - p)) >>> FB;
  endfunction

  function automatic longint grad_dot(input logic [7:0] hash, input longint dx,
                                      input longint dy);
    longint gx, gy;
    case (hash[2:0])
      GRAD_PX: begin gx = UNIT;  gy = 0;     end
      GRAD_NX: begin gx = -UNIT; gy = 0;     end
      GRAD_PY: begin gx = 0;     gy = UNIT;  end
      GRAD_NY: begin gx = 0;     gy = -UNIT; end
      GRAD_PP: begin gx = DIAG;  gy = DIAG;  end
      GRAD_NP: begin gx = -DIAG; gy = DIAG;  end
      GRAD_PN: begin gx = DIAG;  gy = -DIAG; end
      default: begin gx = -DIAG; gy = -DIAG; end
    endcase
    // arithmetic shift floors negative sums
    return (gx * dx + gy * dy) >>> FB;
  endfunction

  function automatic longint mix(input longint f, input longint a, input longint b);
    return a + ((f * (b - a)) >>> FB);
  endfunction

  function automatic logic signed [15:0] perlin_sample(input logic [23:0] xc,
                                                      input logic [23:0] yc);
    longint      fmask, tx, ty, u, v, nx0, nx1, r;
    int unsigned ix, iy, a, b;
    fmask = (longint'(1) << COORD_FRAC_BITS) - 1;
    ix = int'((longint'(xc) >> COORD_FRAC_BITS) & 255);
    iy = int'((longint'(yc) >> COORD_FRAC_BITS) & 255);
    tx = (longint'(xc) & fmask) << (FB - COORD_FRAC_BITS);
    ty = (longint'(yc) & fmask) << (FB - COORD_FRAC_BITS);
    u  = fade_curve(tx);
    v  = fade_curve(ty);
    a  = perm_at(ix) + iy;
    b  = perm_at(ix + 1) + iy;
    nx0 = mix(u, grad_dot(perm_at(perm_at(a)), tx, ty),
              grad_dot(perm_at(perm_at(b)), tx - UNIT, ty));
    nx1 = mix(u, grad_dot(perm_at(perm_at(a + 1)), tx, ty - UNIT),
              grad_dot(perm_at(perm_at(b + 1)), tx - UNIT, ty - UNIT));
    r = mix(v, nx0, nx1);
    if (OUT_FRAC_BITS >= FB) begin
      r = r <<< SCALE_UP;
    end else begin
      r = (r + (longint'(1) << (SCALE_DN - 1))) >>> SCALE_DN;
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: noise mismatch: %s", $time, what);
    mismatches = mismatches + 1;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    noise_expect_t e;
    if (!rst) begin
      if (noise_valid && !noise_stall) begin
        if (pending_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d with no request waiting", noise_value));
        end else begin
          e = pending_samples.pop_front();
          if (noise_value !== e.value) begin
            report_mismatch($sformatf("x=%06h y=%06h got %0d want %0d",
                                      e.x, e.y, noise_value, e.value));
          end
        end
      end
      if (coord_valid && !coord_stall) begin
        e.x     = x_coord;
        e.y     = y_coord;
        e.value = perlin_sample(x_coord, y_coord);
        pending_samples.push_back(e);
      end
    end
    outstanding <= pending_samples.size();
  end

endmodule

[verif/tb_gradient_noise_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d: testbench top for the 2D gradient noise core
// Drives directed and random coordinate requests with random gaps and
// random back-pressure; a side checker recomputes and compares each sample.
// ----------------------------------------------------------------------------
module tb_gradient_noise_2d;

  localparam int CFB         = 16;
  localparam int OFB         = 14;
  localparam int RAND_COUNT  = 1450;
  localparam int DRAIN       = 50;       // well past the pipeline latency
  localparam int CYCLE_LIMIT = 300000;   // watchdog bound for the whole run

  logic               clk = 1'b0;
  logic               rst;
  logic               coord_valid;
  logic               coord_stall;
  logic [23:0]        x_coord;
  logic [23:0]        y_coord;
  logic               noise_valid;
  logic               noise_stall;
  logic signed [15:0] noise_value;

  int mismatches;
  int outstanding;
  int cycle_count = 0;

  // while set, the side in question runs back to back with no idling
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;

  always #5 clk = ~clk;

  gradient_noise_2d #(
    .COORD_FRAC_BITS(CFB),
    .OUT_FRAC_BITS  (OFB)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .coord_valid(coord_valid),
    .coord_stall(coord_stall),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .noise_valid(noise_valid),
    .noise_stall(noise_stall),
    .noise_value(noise_value)
  );

  gn2_noise_checker #(
    .COORD_FRAC_BITS(CFB),
    .OUT_FRAC_BITS  (OFB)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .coord_valid(coord_valid),
    .coord_stall(coord_stall),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .noise_valid(noise_valid),
    .noise_stall(noise_stall),
    .noise_value(noise_value),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  function automatic int idle_cycles(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 8));
  endfunction

  // Coordinate built from a cell index and a fraction inside the cell
  function automatic logic [23:0] cell_point(input int unsigned cell_idx,
                                             input int unsigned frac);
    longint fmask;
    fmask = (longint'(1) << CFB) - 1;
    return 24'((longint'(cell_idx) << CFB) | (longint'(frac) & fmask));
  endfunction

  // One coordinate request: idle gap first (payload scrambled while invalid),
  // then hold valid and payload until the core takes it.
  task automatic send_coord(input logic [23:0] x, input logic [23:0] y);
    int gap;
    gap = idle_cycles(calm_tx);
    repeat (gap) begin
      @(negedge clk);
      coord_valid <= 1'b0;
      x_coord     <= 24'($urandom);
      y_coord     <= 24'($urandom);
    end
    @(negedge clk);
    coord_valid <= 1'b1;
    x_coord     <= x;
    y_coord     <= y;
    do @(posedge clk); while (coord_stall);
  endtask

  // Random coordinate, weighted toward cell borders and the wrap at cell 255
  function automatic logic [23:0] random_coord();
    int unsigned fmax;
    fmax = (1 << CFB) - 1;
    case ($urandom_range(0, 9))
      6:       return cell_point($urandom_range(0, 255), $urandom_range(0, 3));
      7:       return cell_point($urandom_range(0, 255), fmax - $urandom_range(0, 3));
      8:       return cell_point($urandom_range(253, 256), $urandom);
      9:       return cell_point($urandom_range(0, 255), 1 << (CFB - 1));
      default: return 24'($urandom);
    endcase
  endfunction

  // Receiver: stall a random number of cycles, then take one sample
  initial begin
    int n;
    noise_stall = 1'b0;
    forever begin
      n = idle_cycles(calm_rx);
      if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
      repeat (n) begin
        @(negedge clk);
        noise_stall <= 1'b1;
      end
      @(negedge clk);
      noise_stall <= 1'b0;
      do @(posedge clk); while (!noise_valid);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gradient_noise_2d test failed");
      $finish;
    end
  end

  initial begin
    int unsigned half;
    half        = 1 << (CFB - 1);
    rst         = 1'b1;
    coord_valid = 1'b0;
    x_coord     = 24'd0;
    y_coord     = 24'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, lattice points, near-1 fractions, wrap at 255
    send_coord(24'h000000, 24'h000000);
    send_coord(24'hFFFFFF, 24'hFFFFFF);
    send_coord(24'hFFFFFF, 24'h000000);
    send_coord(24'h000000, 24'hFFFFFF);
    send_coord(24'h000001, 24'h000001);
    send_coord(cell_point(255, 0), cell_point(255, 0));
    send_coord(cell_point(255, half), cell_point(0, half));
    send_coord(cell_point(0, half), cell_point(255, half));
    send_coord(cell_point(255, (1 << CFB) - 1), cell_point(1, 1));
    send_coord(24'hAAAAAA, 24'h555555);
    send_coord(24'h555555, 24'hAAAAAA);
    send_coord(cell_point(17, 0), cell_point(200, 0));
    // sweep of cells at the cell center, reaching all eight gradient codes
    for (int i = 0; i < 12; i++) begin
      send_coord(cell_point(i * 37 + 3, half), cell_point(i * 53 + 11, half));
    end

    // Random part with bursts of back-to-back traffic
    for (int i = 0; i < RAND_COUNT; i++) begin
      if ($urandom_range(0, 63) == 0) calm_tx = !calm_tx;
      send_coord(random_coord(), random_coord());
    end
    @(negedge clk);
    coord_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("gradient_noise_2d test passed");
    end else begin
      $display("gradient_noise_2d test failed");
    end
    $finish;
  end

endmodule

[gradient_noise_2d.f]
rtl/core/gn2_pkg.sv
rtl/core/gn2_front.sv
rtl/core/gn2_queue.sv
rtl/core/gn2_back.sv
rtl/core/gradient_noise_2d.sv
verif/gn2_noise_checker.sv
verif/tb_gradient_noise_2d.sv
